### rtl/mvn_pkg.sv
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types, constants and helpers for the mesh vertex normal generator.
// ----------------------------------------------------------------------------
package mvn_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int NORMAL_FRACTION_BITS = 14;

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CORNER_W = 16;
	localparam int COUNT_W = 13;
	localparam int OUT_W = 16;
	localparam int SUM_W = 32;

	// stored coordinate, expanded coordinate, edge, cross product
	localparam int POS_W = 18;
	localparam int PW = POS_W + 1;
	localparam int EDGE_W = PW + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 2;

	localparam int POS_WORD_W = 3 * POS_W;
	localparam int SUM_WORD_W = 3 * SUM_W;

	// normalizer widths
	localparam int MAG_W = 30;
	localparam int SQ_W = 2 * MAG_W;
	localparam int LEN2_W = SQ_W + 2;
	localparam int ROOT_W = MAG_W + 1;
	localparam int QW = NORMAL_FRACTION_BITS + 2;
	localparam int NUM_W = ROOT_W + QW - 1;
	localparam int STEP_W = $clog2(QW);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TRI   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic CFG_FORMAT = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	localparam logic FMT_PACKED = 1'b0;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;
	localparam logic KIND_FACET  = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef struct packed {
		logic [1:0]               op;
		logic [VIDX_W-1:0]        vertex_index;
		logic [31:0]              packed_word;
		logic signed [15:0]       wide_x;
		logic signed [15:0]       wide_y;
		logic signed [15:0]       wide_z;
		logic [CORNER_W-1:0]      corner_a;
		logic [CORNER_W-1:0]      corner_b;
		logic [CORNER_W-1:0]      corner_c;
	} in_item_t;

	typedef struct packed {
		logic                     status;
		logic                     normal_kind;
		logic signed [OUT_W-1:0]  normal_x;
		logic signed [OUT_W-1:0]  normal_y;
		logic signed [OUT_W-1:0]  normal_z;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRD,
		S_EDGE,
		S_CROSS,
		S_NSTART,
		S_NWAIT,
		S_ARD,
		S_AWR,
		S_QRD,
		S_QCAP,
		S_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DINIT,
		N_DIV,
		N_DONE
	} nrm_state_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [OUT_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
		if (s[SUM_W] != s[SUM_W-1])
			sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sat_add = s[SUM_W-1:0];
	endfunction

endpackage

### rtl/mvn_ram.sv
// ----------------------------------------------------------------------------
// mvn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/mvn_norm.sv
// ----------------------------------------------------------------------------
// mvn_norm
// Iterative vector normalizer: range shift, sum of squares, bit-serial
// integer square root, then three restoring divisions to Q1.14.
// ----------------------------------------------------------------------------
module mvn_norm import mvn_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [CROSS_W-1:0]  vec [3],
	output logic                       done,
	output logic signed [OUT_W-1:0]    nrm [3]
);

	nrm_state_t state_q, state_d;

	logic [1:0]              cnt_q;
	logic [1:0]              comp_q;
	logic [STEP_W-1:0]       step_q;

	logic                    neg_q [3];
	logic [CROSS_W-1:0]      mag_q [3];
	logic [SQ_W-1:0]         prod_q;
	logic [LEN2_W-1:0]       len2_q;
	logic [LEN2_W-1:0]       rem_q;
	logic [LEN2_W-1:0]       root_q;
	logic [LEN2_W-1:0]       bit_q;
	logic [NUM_W-1:0]        num_q;
	logic [NUM_W-1:0]        dsh_q;
	logic [QW-1:0]           quo_q;
	logic signed [OUT_W-1:0] nrm_q [3];

	logic               all_zero, big, tiny;
	logic [MAG_W-1:0]   sq_op;
	logic [LEN2_W-1:0]  trial;
	logic [ROOT_W-1:0]  len;
	logic               ge;
	logic [QW-1:0]      qf;
	logic signed [OUT_W-1:0] qs;
	logic               last_step;

	always_comb begin
		all_zero = 1'b1;
		big = 1'b0;
		tiny = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i] != '0)
				all_zero = 1'b0;
			if (mag_q[i][CROSS_W-1:MAG_W] != '0)
				big = 1'b1;
			if (mag_q[i][CROSS_W-1:MAG_W-1] != '0)
				tiny = 1'b0;
		end
	end

	always_comb begin
		unique case (cnt_q)
			2'd0: sq_op = mag_q[0][MAG_W-1:0];
			2'd1: sq_op = mag_q[1][MAG_W-1:0];
			default: sq_op = mag_q[2][MAG_W-1:0];
		endcase
	end

	assign trial = root_q + bit_q;
	assign len = root_q[ROOT_W-1:0];
	assign ge = num_q >= dsh_q;
	assign qf = {quo_q[QW-2:0], ge};
	assign last_step = step_q == STEP_W'(QW - 1);

	// sign and clamp of the finished quotient
	always_comb begin
		if (!neg_q[comp_q])
			qs = qf[QW-1] ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(qf);
		else if (qf[QW-1] && qf[QW-2:0] != '0)
			qs = {1'b1, {(OUT_W-1){1'b0}}};
		else
			qs = -OUT_W'(qf);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE:  if (start) state_d = N_SHIFT;
			N_SHIFT: begin
				if (all_zero)
					state_d = N_DONE;
				else if (!big && !tiny)
					state_d = N_SQ;
			end
			N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
			N_SQRT:  if (bit_q[0]) state_d = N_DINIT;
			N_DINIT: state_d = N_DIV;
			N_DIV:   if (last_step) state_d = (comp_q == 2'd2) ? N_DONE : N_DINIT;
			N_DONE:  state_d = N_IDLE;
			default: state_d = N_IDLE;
		endcase
	end

	assign done = state_q == N_DONE;
	assign nrm = nrm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == N_IDLE) begin
				cnt_q <= '0;
				comp_q <= '0;
			end
			if (state_q == N_SQ)
				cnt_q <= cnt_q + 2'd1;
			if (state_q == N_DINIT)
				step_q <= '0;
			if (state_q == N_DIV) begin
				step_q <= step_q + 1'b1;
				if (last_step)
					comp_q <= comp_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec[i][CROSS_W-1];
						mag_q[i] <= vec[i][CROSS_W-1] ? CROSS_W'(-vec[i]) : CROSS_W'(vec[i]);
						nrm_q[i] <= '0;
					end
				end
			end
			N_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (big)
						mag_q[i] <= mag_q[i] >> 1;
					else if (tiny)
						mag_q[i] <= mag_q[i] << 1;
				end
			end
			N_SQ: begin
				if (cnt_q != 2'd3)
					prod_q <= sq_op * sq_op;
				if (cnt_q == 2'd0)
					len2_q <= '0;
				else if (cnt_q == 2'd3) begin
					rem_q <= len2_q + LEN2_W'(prod_q);
					root_q <= '0;
					bit_q <= LEN2_W'(1) << (LEN2_W - 2);
				end else
					len2_q <= len2_q + LEN2_W'(prod_q);
			end
			N_SQRT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else
					root_q <= root_q >> 1;
				bit_q <= bit_q >> 2;
			end
			N_DINIT: begin
				num_q <= (NUM_W'(mag_q[comp_q][MAG_W-1:0]) << NORMAL_FRACTION_BITS)
					+ NUM_W'(len >> 1);
				dsh_q <= NUM_W'(len) << (QW - 1);
				quo_q <= '0;
			end
			N_DIV: begin
				if (ge)
					num_q <= num_q - dsh_q;
				quo_q <= qf;
				dsh_q <= dsh_q >> 1;
				if (last_step)
					nrm_q[comp_q] <= qs;
			end
			default: ;
		endcase
	end

endmodule

### rtl/mesh_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_generator
// Facet and smoothed vertex normals of a triangle mesh, kept in two RAMs.
// ----------------------------------------------------------------------------
// Load writes the position and clears the sum. Triangle: corner reads, edges, cross
//   product, normalize, corner-sum updates (out of range: straight to result); query:
//   sum read, normalize. Normalizer: one range shift per cycle, squaring, root, division.
// One request at a time; a finished result waits in the output register.
// Reset clears control and config; the RAMs hold garbage until loaded.
module mesh_vertex_normal_generator import mvn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	ctl_state_t state_q, state_d;

	logic               format_q;
	logic [COUNT_W-1:0] count_q;
	logic [2:0]         cnt_q;

	logic [VIDX_W-1:0]  corner_q [3];
	logic [VIDX_W-1:0]  slot_q;
	logic               status_q, kind_q;
	logic signed [PW-1:0]      pos_q [3][3];
	logic signed [EDGE_W-1:0]  e0_q [3];
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [CROSS_W-1:0] vec_q [3];
	logic signed [OUT_W-1:0]   nres_q [3];
	logic      out_valid_q;
	out_item_t out_q;

	logic in_acc;
	logic pos_we, sum_we;
	logic [VIDX_W-1:0] pos_raddr, sum_raddr, sum_waddr;
	logic [POS_WORD_W-1:0] pos_wdata, pos_rdata;
	logic [SUM_WORD_W-1:0] sum_wdata, sum_rdata;
	logic nstart, ndone;
	logic signed [OUT_W-1:0] nrm [3];
	logic tri_ok;
	logic signed [POS_W-1:0] ld_x, ld_y, ld_ny;
	logic signed [EDGE_W-1:0] mul_a, mul_b;
	logic [1:0] acc_tgt;
	logic acc_sub;

	function automatic logic in_range(input logic [CORNER_W-1:0] i, input logic [COUNT_W-1:0] c);
		in_range = ({1'b0, i} < (CORNER_W+1)'(c)) && ({1'b0, i} < (CORNER_W+1)'(MAX_VERTICES));
	endfunction

	assign in_stall = state_q != S_IDLE;
	assign in_acc = in_valid && !in_stall;
	assign tri_ok = in_range(in_data.corner_a, count_q) && in_range(in_data.corner_b, count_q)
		&& in_range(in_data.corner_c, count_q);

	// stored as (x, y', -z'') with the last axis kept un-negated
	always_comb begin
		if (format_q == FMT_PACKED) begin
			ld_x = POS_W'($signed(in_data.packed_word[10:0]));
			ld_y = POS_W'($signed({in_data.packed_word[31:22], 1'b0}));
			ld_ny = POS_W'($signed(in_data.packed_word[21:11]));
		end else begin
			ld_x = POS_W'($signed({in_data.wide_x, 2'b00}));
			ld_y = POS_W'($signed({in_data.wide_z, 2'b00}));
			ld_ny = POS_W'($signed({in_data.wide_y, 2'b00}));
		end
	end

	assign pos_wdata = {ld_ny, ld_y, ld_x};

	mvn_ram #(.WIDTH(POS_WORD_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (in_data.vertex_index),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	mvn_ram #(.WIDTH(SUM_WORD_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.vec    (vec_q),
		.done   (ndone),
		.nrm    (nrm)
	);

	// cross product terms, one multiply per cycle
	always_comb begin
		unique case (cnt_q)
			3'd0: begin mul_a = e0_q[1]; mul_b = e1_q[2]; end
			3'd1: begin mul_a = e0_q[2]; mul_b = e1_q[1]; end
			3'd2: begin mul_a = e0_q[2]; mul_b = e1_q[0]; end
			3'd3: begin mul_a = e0_q[0]; mul_b = e1_q[2]; end
			3'd4: begin mul_a = e0_q[0]; mul_b = e1_q[1]; end
			default: begin mul_a = e0_q[1]; mul_b = e1_q[0]; end
		endcase
	end

	// product from the previous step lands here
	assign acc_tgt = (cnt_q <= 3'd2) ? 2'd0 : (cnt_q <= 3'd4) ? 2'd1 : 2'd2;
	assign acc_sub = !cnt_q[0];

	always_comb begin
		state_d = state_q;
		pos_we = 1'b0;
		sum_we = 1'b0;
		pos_raddr = corner_q[0];
		sum_raddr = corner_q[0];
		sum_waddr = in_data.vertex_index;
		sum_wdata = '0;
		nstart = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (op_t'(in_data.op))
						OP_LOAD: begin
							pos_we = 1'b1;
							sum_we = 1'b1;
						end
						OP_TRI:   state_d = tri_ok ? S_PRD : S_DONE;
						OP_QUERY: state_d = S_QRD;
						default: ;
					endcase
				end
			end
			S_PRD: begin
				if (cnt_q < 3'd3)
					pos_raddr = corner_q[cnt_q[1:0]];
				if (cnt_q == 3'd3)
					state_d = S_EDGE;
			end
			S_EDGE:  state_d = S_CROSS;
			S_CROSS: if (cnt_q == 3'd6) state_d = S_NSTART;
			S_NSTART: begin
				nstart = 1'b1;
				state_d = S_NWAIT;
			end
			S_NWAIT: if (ndone) state_d = (kind_q == KIND_FACET) ? S_ARD : S_DONE;
			S_ARD: begin
				sum_raddr = corner_q[cnt_q[1:0]];
				state_d = S_AWR;
			end
			S_AWR: begin
				sum_we = 1'b1;
				sum_waddr = corner_q[cnt_q[1:0]];
				sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], nres_q[2]),
					sat_add(sum_rdata[2*SUM_W-1:SUM_W], nres_q[1]),
					sat_add(sum_rdata[SUM_W-1:0], nres_q[0])};
				state_d = (cnt_q == 3'd2) ? S_DONE : S_ARD;
			end
			S_QRD: begin
				sum_raddr = slot_q;
				state_d = S_QCAP;
			end
			S_QCAP: state_d = S_NSTART;
			S_DONE: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			format_q <= 1'b0;
			count_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FORMAT: format_q <= cfg_wdata[0];
					CFG_COUNT:  count_q <= cfg_wdata;
					default: ;
				endcase
			end
			// corner counter runs across the read and write halves of each sum update
			unique case (state_q)
				S_PRD, S_CROSS, S_AWR: cnt_q <= cnt_q + 3'd1;
				S_ARD: ;
				default: cnt_q <= '0;
			endcase
			if (state_q == S_DONE && state_d == S_IDLE)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			corner_q[0] <= in_data.corner_a[VIDX_W-1:0];
			corner_q[1] <= in_data.corner_b[VIDX_W-1:0];
			corner_q[2] <= in_data.corner_c[VIDX_W-1:0];
			slot_q <= in_data.vertex_index;
			kind_q <= (in_data.op == OP_QUERY) ? KIND_VERTEX : KIND_FACET;
			status_q <= (in_data.op == OP_TRI && !tri_ok) ? ST_RANGE : ST_OK;
			for (int i = 0; i < 3; i++)
				nres_q[i] <= '0;
		end
		if (state_q == S_PRD && cnt_q != 3'd0) begin
			pos_q[cnt_q[1:0]-2'd1][0] <= PW'($signed(pos_rdata[POS_W-1:0]));
			pos_q[cnt_q[1:0]-2'd1][1] <= PW'($signed(pos_rdata[2*POS_W-1:POS_W]));
			pos_q[cnt_q[1:0]-2'd1][2] <= -PW'($signed(pos_rdata[3*POS_W-1:2*POS_W]));
		end
		if (state_q == S_EDGE) begin
			for (int i = 0; i < 3; i++) begin
				e0_q[i] <= EDGE_W'(pos_q[1][i]) - EDGE_W'(pos_q[0][i]);
				e1_q[i] <= EDGE_W'(pos_q[2][i]) - EDGE_W'(pos_q[0][i]);
				vec_q[i] <= '0;
			end
		end
		if (state_q == S_CROSS) begin
			if (cnt_q != 3'd6)
				prod_s1 <= mul_a * mul_b;
			if (cnt_q != 3'd0) begin
				if (acc_sub)
					vec_q[acc_tgt] <= vec_q[acc_tgt] - CROSS_W'(prod_s1);
				else
					vec_q[acc_tgt] <= vec_q[acc_tgt] + CROSS_W'(prod_s1);
			end
		end
		if (state_q == S_QCAP) begin
			vec_q[0] <= CROSS_W'($signed(sum_rdata[SUM_W-1:0]));
			vec_q[1] <= CROSS_W'($signed(sum_rdata[2*SUM_W-1:SUM_W]));
			vec_q[2] <= CROSS_W'($signed(sum_rdata[3*SUM_W-1:2*SUM_W]));
		end
		if (state_q == S_NWAIT && ndone)
			nres_q <= nrm;
		if (state_q == S_DONE && state_d == S_IDLE) begin
			out_q.status <= status_q;
			out_q.normal_kind <= kind_q;
			out_q.normal_x <= nres_q[0];
			out_q.normal_y <= nres_q[1];
			out_q.normal_z <= nres_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### rtl/mvn_checker.sv
// ----------------------------------------------------------------------------
// mvn_checker
// Port-level checks for the mesh vertex normal generator.
// ----------------------------------------------------------------------------
module mvn_checker import mvn_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      cfg_we,
	input logic      cfg_index,
	input logic [COUNT_W-1:0] cfg_wdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_tri: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.op == OP_TRI || in_data.op == OP_QUERY) |=> in_stall)
		else $error("triangle or query request did not make the block busy");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_RANGE |->
		out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0
		&& out_data.normal_kind == KIND_FACET)
		else $error("out-of-range result carries a nonzero normal");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.normal_x >= -16384 && out_data.normal_x <= 16384
		&& out_data.normal_y >= -16384 && out_data.normal_y <= 16384
		&& out_data.normal_z >= -16384 && out_data.normal_z <= 16384)
		else $error("normal component outside unit range");

endmodule

bind mesh_vertex_normal_generator mvn_checker u_mvn_checker (.*);
